FILE: rtl/gcas_pkg.sv
package gcas_pkg;

    // character and result widths
    localparam int CHAR_W = 8;
    localparam int SUM_W  = 32;
    localparam int ROW_W  = 16;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE      = 8'd10;
    localparam logic [CHAR_W-1:0] PATH_SYMBOL_RESET = 8'd35;

    localparam logic signed [ROW_W-1:0] ROW_RESET = -16'sd1;
    localparam logic signed [ROW_W-1:0] ROW_MAX   = 16'sd32767;

    // scan pipeline depth after the last read is issued
    localparam int FLUSH_CYCLES = 3;
    localparam int FLUSH_W      = 2;

    typedef logic [1:0] bank_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } gcas_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic scan_step;
        logic row_end;
        logic char_wr;
        logic eos_take;
    } gcas_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic out_busy;
    } gcas_stat_t;

    // bank roles rotate: upper = phase, middle = phase+1, lower = phase+2 (mod 3)
    function automatic bank_idx_t bank_inc(input bank_idx_t idx);
        bank_idx_t res;
        res = (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        return res;
    endfunction

    function automatic bank_idx_t bank_dec(input bank_idx_t idx);
        bank_idx_t res;
        res = (idx == 2'd0) ? 2'd2 : idx - 2'd1;
        return res;
    endfunction

endpackage

FILE: rtl/gcas_in_if.sv
interface gcas_in_if;
    logic                       valid;
    logic                       ready;
    logic [gcas_pkg::CHAR_W-1:0] char_code;
    logic                       end_of_stream;

    modport source (output valid, output char_code, output end_of_stream, input ready);
    modport sink   (input valid, input char_code, input end_of_stream, output ready);
endinterface

FILE: rtl/gcas_out_if.sv
interface gcas_out_if;
    logic                       valid;
    logic                       ready;
    logic [gcas_pkg::SUM_W-1:0] alignment_sum;

    modport source (output valid, output alignment_sum, input ready);
    modport sink   (input valid, input alignment_sum, output ready);
endinterface

FILE: rtl/gcas_ctrl.sv
module gcas_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [gcas_pkg::CHAR_W-1:0] char_code,
    input  logic                        end_of_stream,
    output logic                        in_ready,
    input  gcas_pkg::gcas_stat_t        stat,
    output gcas_pkg::gcas_cmd_t         cmd
);
    import gcas_pkg::*;

    gcas_state_t        state_reg, state_next;
    logic [FLUSH_W-1:0] flush_reg, flush_next;
    logic               accept;

    // state and flush counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            flush_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE) && !stat.out_busy;
    assign accept   = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (end_of_stream)
                    begin
                        cmd.eos_take = 1'b1;
                        state_next   = ST_CLEAR;
                    end
                    else if (char_code == NEWLINE_CODE)
                        state_next = ST_SCAN;
                    else
                        cmd.char_wr = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_FLUSH;
                    flush_next = '0;
                end
            end
            ST_FLUSH:
            begin
                if (flush_reg == FLUSH_W'(FLUSH_CYCLES - 1))
                begin
                    cmd.row_end = 1'b1;
                    flush_next  = '0;
                    state_next  = ST_IDLE;
                end
                else
                    flush_next = flush_reg + 1'b1;
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // a newline starts a row scan
    a_newline_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !end_of_stream && char_code == NEWLINE_CODE) |=> state_reg == ST_SCAN)
        else $error("newline did not start a scan");

    // end of row is a single pulse followed by idle
    a_row_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_end |=> (!cmd.row_end && state_reg == ST_IDLE))
        else $error("row end not followed by idle");

    // end of stream always starts a clearing pass
    a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eos_take |=> cmd.clear_step)
        else $error("end of stream without clearing pass");

endmodule

FILE: rtl/gcas_datapath.sv
module gcas_datapath #(
    parameter int LINE_WIDTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gcas_pkg::gcas_cmd_t         cmd,
    output gcas_pkg::gcas_stat_t        stat,
    input  logic [gcas_pkg::CHAR_W-1:0] char_code,
    input  logic                        cfg_wr_en,
    input  logic [gcas_pkg::CHAR_W-1:0] cfg_wr_data,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [gcas_pkg::SUM_W-1:0]  alignment_sum
);
    import gcas_pkg::*;

    localparam int AW    = $clog2(LINE_WIDTH);
    localparam int COL_W = $clog2(LINE_WIDTH + 1);
    localparam int PW    = ROW_W + AW + 1;
    localparam int ACC_W = SUM_W + 2;

    logic [CHAR_W-1:0]       path_symbol_reg;
    logic [AW-1:0]           sweep_reg, sweep_next;
    logic [COL_W-1:0]        column_reg, column_next;
    logic signed [ROW_W-1:0] row_reg, row_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    bank_idx_t               phase_reg;
    logic                    out_valid_reg;
    logic [SUM_W-1:0]        out_sum_reg;

    bank_idx_t               upper_idx, middle_idx, lower_idx;
    logic                    col_ok;
    logic [CHAR_W-1:0]       rd_data [3];

    logic                    s1_v_reg;
    logic [AW-1:0]           s1_col_reg;
    logic                    s2_v_reg;
    logic [AW-1:0]           s2_col_reg;
    logic [2:0]              m_win_reg;
    logic [1:0]              u_win_reg, l_win_reg;
    logic                    u_eq, m_eq, l_eq;
    logic                    junction;
    logic [AW-1:0]           jcol;
    logic                    prod_v_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_sum;
    logic [SUM_W-1:0]        acc_clamped;

    assign upper_idx  = phase_reg;
    assign middle_idx = bank_inc(phase_reg);
    assign lower_idx  = bank_dec(phase_reg);
    assign col_ok     = column_reg != COL_W'(LINE_WIDTH);

    // sweep counter shared by clearing pass and row scan; wraps to zero
    assign stat.sweep_last = sweep_reg == AW'(LINE_WIDTH - 1);
    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.clear_step || cmd.scan_step)
            sweep_next = stat.sweep_last ? '0 : sweep_reg + 1'b1;
    end

    // three line banks; copy of the lower row into the old upper bank rides the scan
    for (genvar b = 0; b < 3; b++)
    begin : g_bank
        logic [CHAR_W-1:0] mem [LINE_WIDTH];
        logic [CHAR_W-1:0] rd_reg;
        logic              we;
        logic [AW-1:0]     wr_addr;
        logic [CHAR_W-1:0] wr_data;

        always_comb
        begin
            we      = 1'b0;
            wr_addr = sweep_reg;
            wr_data = '0;
            if (cmd.clear_step)
                we = 1'b1;
            else if (cmd.char_wr && col_ok && lower_idx == bank_idx_t'(b))
            begin
                we      = 1'b1;
                wr_addr = column_reg[AW-1:0];
                wr_data = char_code;
            end
            else if (s1_v_reg && upper_idx == bank_idx_t'(b))
            begin
                we      = 1'b1;
                wr_addr = s1_col_reg;
                wr_data = rd_data[lower_idx];
            end
        end

        always_ff @(posedge clk)
        begin
            if (we)
                mem[wr_addr] <= wr_data;
            rd_reg <= mem[sweep_reg];
        end

        assign rd_data[b] = rd_reg;
    end

    // cell matches on the read data
    assign u_eq = rd_data[upper_idx]  == path_symbol_reg;
    assign m_eq = rd_data[middle_idx] == path_symbol_reg;
    assign l_eq = rd_data[lower_idx]  == path_symbol_reg;

    // junction at the column behind the newest middle cell
    assign jcol     = s2_col_reg - 1'b1;
    assign junction = s2_v_reg && (s2_col_reg >= AW'(2)) && (&m_win_reg)
                      && u_win_reg[1] && l_win_reg[1];

    // saturating accumulate, floored at zero
    always_comb
    begin
        acc_sum = $signed({2'b00, sum_reg}) + ACC_W'(prod_reg);
        if (acc_sum[ACC_W-1])
            acc_clamped = '0;
        else if (acc_sum[ACC_W-2:SUM_W] != '0)
            acc_clamped = '1;
        else
            acc_clamped = acc_sum[SUM_W-1:0];
    end

    // next values of the row state
    always_comb
    begin
        sum_next    = sum_reg;
        row_next    = row_reg;
        column_next = column_reg;
        if (cmd.eos_take)
        begin
            sum_next    = '0;
            row_next    = ROW_RESET;
            column_next = '0;
        end
        else
        begin
            if (prod_v_reg)
                sum_next = acc_clamped;
            if (cmd.row_end)
            begin
                column_next = '0;
                if (row_reg != ROW_MAX)
                    row_next = row_reg + ROW_W'(1);
            end
            else if (cmd.char_wr && col_ok)
                column_next = column_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_symbol_reg <= PATH_SYMBOL_RESET;
            sweep_reg       <= '0;
            column_reg      <= '0;
            row_reg         <= ROW_RESET;
            sum_reg         <= '0;
            phase_reg       <= '0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            prod_v_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                path_symbol_reg <= cfg_wr_data;
            sweep_reg  <= sweep_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            sum_reg    <= sum_next;
            if (cmd.row_end)
                phase_reg <= bank_inc(phase_reg);
            s1_v_reg   <= cmd.scan_step;
            s2_v_reg   <= s1_v_reg;
            prod_v_reg <= junction;
            if (cmd.eos_take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // scan pipeline and result payload
    always_ff @(posedge clk)
    begin
        s1_col_reg <= sweep_reg;
        if (s1_v_reg)
        begin
            m_win_reg  <= {m_win_reg[1:0], m_eq};
            u_win_reg  <= {u_win_reg[0], u_eq};
            l_win_reg  <= {l_win_reg[0], l_eq};
            s2_col_reg <= s1_col_reg;
        end
        prod_reg <= PW'(row_reg) * PW'($signed({1'b0, jcol}));
        if (cmd.eos_take)
            out_sum_reg <= sum_reg;
    end

    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign alignment_sum = out_sum_reg;

    // column never runs past the line
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= COL_W'(LINE_WIDTH))
        else $error("column past line width");

    // end of stream resets row state
    a_eos_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eos_take |=> (sum_reg == '0 && row_reg == ROW_RESET && column_reg == '0))
        else $error("state not cleared on end of stream");

    // no accumulation outside a row scan
    a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
        prod_v_reg |-> !(cmd.char_wr || cmd.eos_take || cmd.clear_step))
        else $error("accumulate outside scan");

endmodule

FILE: rtl/grid_cross_alignment_sum.sv
// Characters can be accepted every cycle, but not during a newline scan or clearing pass,
// nor while a shown sum waits on a stalled result channel. A newline makes one pass over
// the line banks (one column per cycle on the bank read port) plus a three-stage
// match/multiply/add pipeline. End of stream: the sum is shown the cycle after acceptance,
// then a clearing pass zeroes the banks before the next word is taken.
// Reset (asynchronous, active low) also starts a clearing pass.
module grid_cross_alignment_sum #(
    parameter int LINE_WIDTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    gcas_in_if.sink                     text,
    gcas_out_if.source                  result,
    input  logic                        cfg_wr_en,
    input  logic [gcas_pkg::CHAR_W-1:0] cfg_wr_data
);
    import gcas_pkg::*;

    gcas_cmd_t  cmd;
    gcas_stat_t stat;

    // sequencer
    gcas_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (text.valid),
        .char_code     (text.char_code),
        .end_of_stream (text.end_of_stream),
        .in_ready      (text.ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // line banks, scan pipeline and accumulator
    gcas_datapath #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .char_code     (text.char_code),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .alignment_sum (result.alignment_sum)
    );

endmodule

FILE: tb/gcas_checker.sv
// Watches the text and result channels, keeps its own copy of the three line
// stores and checks every emitted alignment sum against the predicted one.
module gcas_checker #(
    parameter int LINE_WIDTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        text_valid,
    input  logic                        text_ready,
    input  logic [gcas_pkg::CHAR_W-1:0] char_code,
    input  logic                        end_of_stream,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic [gcas_pkg::SUM_W-1:0]  alignment_sum,
    input  logic                        cfg_wr_en,
    input  logic [gcas_pkg::CHAR_W-1:0] cfg_wr_data,
    output int                          errors,
    output int                          pending
);
    import gcas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    COL_W   = $clog2(LINE_WIDTH + 1);
    localparam longint SUM_SAT = 64'd4294967295;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_stream;
    } text_word_t;

    // predicted block state
    logic [CHAR_W-1:0]        path_sym;
    logic [CHAR_W-1:0]        upper_cells [LINE_WIDTH];
    logic [CHAR_W-1:0]        mid_cells   [LINE_WIDTH];
    logic [CHAR_W-1:0]        low_cells   [LINE_WIDTH];
    logic [COL_W-1:0]         col_pos;
    logic signed [ROW_W-1:0]  row_idx;
    logic [SUM_W-1:0]         junction_sum;

    // sums owed by the block, oldest first
    logic [SUM_W-1:0]         owed_sums [$];

    function automatic void clear_raster();
        for (int c = 0; c < LINE_WIDTH; c++)
        begin
            upper_cells[c] = '0;
            mid_cells[c]   = '0;
            low_cells[c]   = '0;
        end
        col_pos      = '0;
        row_idx      = ROW_RESET;
        junction_sum = '0;
    endfunction

    // newline: scan the middle row for crosses, then shift the rows up
    function automatic void close_row();
        longint acc;
        acc = longint'(junction_sum);
        for (int c = 1; c + 1 < LINE_WIDTH; c++)
        begin
            if (upper_cells[c] == path_sym && mid_cells[c-1] == path_sym &&
                mid_cells[c] == path_sym && mid_cells[c+1] == path_sym &&
                low_cells[c] == path_sym)
            begin
                acc = acc + longint'(row_idx) * c;
                if (acc > SUM_SAT)
                    acc = SUM_SAT;
                if (acc < 0)
                    acc = 0;
            end
        end
        junction_sum = acc[SUM_W-1:0];
        upper_cells  = mid_cells;
        mid_cells    = low_cells;
        col_pos      = '0;
        if (row_idx != ROW_MAX)
            row_idx = row_idx + ROW_W'(1);
    endfunction

    function automatic void take_word(input text_word_t w);
        if (w.end_of_stream)
        begin
            owed_sums.push_back(junction_sum);
            clear_raster();
        end
        else if (w.char_code == NEWLINE_CODE)
            close_row();
        else if (col_pos < LINE_WIDTH)
        begin
            low_cells[col_pos] = w.char_code;
            col_pos = col_pos + 1'b1;
        end
    endfunction

    // sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [SUM_W-1:0] wanted;
        if (!rst_n)
        begin
            path_sym = PATH_SYMBOL_RESET;
            clear_raster();
            owed_sums.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                path_sym = cfg_wr_data;
            if (text_valid && text_ready)
                take_word('{char_code: char_code, end_of_stream: end_of_stream});
            if (result_valid && result_ready)
            begin
                if (owed_sums.size() == 0)
                begin
                    $error("alignment_sum: no sum expected, actual %0d", alignment_sum);
                    errors <= errors + 1;
                end
                else
                begin
                    wanted = owed_sums.pop_front();
                    if (alignment_sum !== wanted)
                    begin
                        $error("alignment_sum: expected %0d, actual %0d",
                               wanted, alignment_sum);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= owed_sums.size();
        end
    end

endmodule

FILE: tb/tb_grid_cross_alignment_sum.sv
module tb_grid_cross_alignment_sum;
    import gcas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_WIDTH    = 256;
    localparam int STALL_LIMIT   = 10000;
    localparam int SETTLE_CYCLES = LINE_WIDTH + 44;
    localparam int HOLD_CYCLES   = 1500;
    localparam int OVERFLOW_ROWS = 560;
    localparam int PHASE_WORDS   = 180;
    localparam int MIN_WORDS     = 1600;
    localparam logic [CHAR_W-1:0] FILL_CODE = 8'h2E;

    // idle modes: none, sender only, receiver only, both
    localparam int SEND_IDLE [4] = '{0, 69, 0, 23};
    localparam int RECV_STALL[4] = '{0, 0, 69, 23};

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CHAR_W-1:0] cfg_wr_data;

    gcas_in_if  text ();
    gcas_out_if result ();

    int errors;
    int pending;
    int words_sent = 0;
    int idle_run   = 0;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_req   = 0;
    logic [CHAR_W-1:0] path_sym = PATH_SYMBOL_RESET;

    grid_cross_alignment_sum #(
        .LINE_WIDTH(LINE_WIDTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .result     (result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    gcas_checker #(
        .LINE_WIDTH(LINE_WIDTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text.valid),
        .text_ready   (text.ready),
        .char_code    (text.char_code),
        .end_of_stream(text.end_of_stream),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .alignment_sum(result.alignment_sum),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .errors       (errors),
        .pending      (pending)
    );

    // 12 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one word on the text channel, with random idle cycles ahead of it
    task automatic send_word(input logic [CHAR_W-1:0] code, input logic eos);
        while ($urandom_range(0, 99) < send_idle)
        begin
            text.valid <= 1'b0;
            @(posedge clk);
        end
        text.valid         <= 1'b1;
        text.char_code     <= code;
        text.end_of_stream <= eos;
        do
            @(posedge clk);
        while (text.ready !== 1'b1);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // stop offering and wait until every owed sum has come out
    task automatic wait_for_sums();
        text.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_path(input logic [CHAR_W-1:0] sym);
        wait_for_sums();
        // a newline scan or a clearing pass may still be running
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sym;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        path_sym = sym;
    endtask

    // mostly path cells so crosses form, some filler, a little noise
    function automatic logic [CHAR_W-1:0] pick_cell();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return path_sym;
        else if (r < 90)
            return FILL_CODE;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_raster();
        int lines;
        int len;
        int r;
        lines = $urandom_range(1, 6);
        repeat (lines)
        begin
            r = $urandom_range(0, 99);
            if (r < 89)
                len = $urandom_range(0, 12);
            else if (r < 99)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(LINE_WIDTH - 6, LINE_WIDTH + 40);
            repeat (len) send_word(pick_cell(), 1'b0);
            // occasionally leave the line open
            if ($urandom_range(0, 99) >= 5)
                send_word(NEWLINE_CODE, 1'b0);
        end
        send_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 20))
            send_word(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 10);
    endtask

    task automatic random_item();
        if ($urandom_range(0, 99) < 85)
            send_raster();
        else
            send_noise();
    endtask

    // result side: random stalls, or one long hold-off on request
    initial
    begin : sink
        int n;
        @(posedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                n = hold_req;
                hold_req = 0;
                result.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                result.ready <= ($urandom_range(0, 99) >= recv_stall);
                @(posedge clk);
            end
        end
    end

    // watchdog: cycles with no word accepted on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text.valid && text.ready) || (result.valid && result.ready))
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("tb_grid_cross_alignment_sum NOT OK");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int start;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        text.valid         = 1'b0;
        text.char_code     = '0;
        text.end_of_stream = 1'b0;
        result.ready       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one cross at row 1 column 1 under the reset symbol,
        // end of stream with ignored characters, empty raster, extreme codes
        send_text(".#.\n###\n.#.\n");
        send_word(NEWLINE_CODE, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(NEWLINE_CODE, 1'b0);
        send_word(8'h00, 1'b1);

        // random rasters, one idle mode and one path symbol per phase
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: write_path(PATH_SYMBOL_RESET);
                1: write_path(8'h00);
                2: write_path(8'hFF);
                default: write_path(CHAR_W'($urandom_range(0, 255)));
            endcase
            send_idle  = SEND_IDLE[p];
            recv_stall = RECV_STALL[p];
            start = words_sent;
            while (words_sent - start < PHASE_WORDS)
                random_item();
        end

        // result side held off while rasters keep coming, so the input backs up
        send_idle  = 0;
        recv_stall = 0;
        write_path(PATH_SYMBOL_RESET);
        hold_req = HOLD_CYCLES;
        repeat (3)
        begin
            send_text(".#.\n###\n.#.\n");
            send_word(8'h00, 1'b1);
        end
        wait_for_sums();

        // sum saturation: one full path line, then stale rows pile up
        repeat (LINE_WIDTH + 3) send_word(path_sym, 1'b0);
        repeat (OVERFLOW_ROWS) send_word(NEWLINE_CODE, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h00, 1'b1);

        // top up to the word count
        send_idle  = SEND_IDLE[3];
        recv_stall = RECV_STALL[3];
        while (words_sent < MIN_WORDS)
            random_item();

        wait_for_sums();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_grid_cross_alignment_sum OK");
        else
            $display("tb_grid_cross_alignment_sum NOT OK");
        $finish;
    end

endmodule
